// ----- hw/rtl/vfgm_pkg.sv -----
package vfgm_pkg;

    localparam int MAX_DIM   = 32;
    localparam int PLANES    = MAX_DIM + 1;
    localparam int ROW_COUNT = 6 * PLANES * MAX_DIM;
    localparam int ADDR_W    = $clog2(ROW_COUNT);
    localparam int ROW_W     = MAX_DIM;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_FETCH = 2'd2;

    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_RECT    = 3'd1;
    localparam logic [2:0] ST_DONE_OK = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_NO_SAVE = 3'd6;

    localparam logic [2:0] FACE_DONE = 3'd6;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;
    localparam logic [1:0] REG_EXACT  = 2'd3;

    localparam logic [18:0] COUNT_MAX = 19'h7FFFF;

    typedef logic [ROW_W-1:0] row_t;

    function automatic logic [ADDR_W-1:0] row_addr(logic [2:0] f, logic [5:0] p,
                                                   logic [4:0] r);
        return ADDR_W'(int'(f) * PLANES * MAX_DIM + int'(p) * MAX_DIM + int'(r));
    endfunction

    function automatic row_t low_ones(logic [5:0] w);
        row_t m;
        m = '0;
        for (int i = 0; i < ROW_W; i++) begin
            m[i] = (i < int'(w));
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/vfgm_ram.sv -----
module vfgm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/voxel_face_greedy_mesher_top.sv -----
// Greedy voxel face mesher.
// Input stream (s_): one command per transfer. s_tuser carries cmd (clear,
// load slab, fetch next rectangle); s_tdata carries the slab column.
// Result stream (m_): exactly one result per command. m_tuser carries the
// status, m_tdata the rectangle and the running triangle total.
// Configuration: cfg_wr_en writes register cfg_addr (size_x, size_y, size_z,
// exact_triangle_count) with cfg_wdata; write only while idle.
// All face masks live in one 6336 x 32 row memory with a registered read.
// Clear writes zero to one memory row per cycle.
// Load does a read-modify-write of one row per face write: up to 4 per z
// voxel plus top and bottom.
// Fetch scans one row at a time until a set row is found, then checks
// each further row of the rectangle's height in turn.
// After reset the block runs the same clearing pass over all rows and holds
// s_tready low. A new command is taken while a result waits; when the
// receiver stalls, the finished result holds and the next one waits.
module voxel_face_greedy_mesher_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // slab_x, slab_y, slab_top, slab_length, face_bits, pad
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // face_dir, plane_index, rect_u, rect_v, rect_width,
                                   // rect_height, triangle_total, pad
    output logic [2:0]  m_tuser,   // status
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wdata
);
    import vfgm_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LDSEL = 4'd2;
    localparam logic [3:0] S_LDWR  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_SDATA = 4'd5;
    localparam logic [3:0] S_FIND  = 4'd6;
    localparam logic [3:0] S_RUN   = 4'd7;
    localparam logic [3:0] S_SPAN  = 4'd8;
    localparam logic [3:0] S_HREAD = 4'd9;
    localparam logic [3:0] S_HCHK  = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic [5:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [23:0] exact_reg;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic        clr_reply_reg, clr_reply_next;
    logic        range_err_reg, range_err_next;
    logic        seen_reg, seen_next;
    logic [18:0] count_reg, count_next;
    logic [2:0]  face_reg, face_next;
    logic [5:0]  plane_reg, plane_next;
    logic [5:0]  row_reg, row_next;
    logic [5:0]  h_reg, h_next;
    logic [5:0]  w_reg, w_next;
    logic [4:0]  u_reg, u_next;
    row_t        bits_reg, bits_next;
    row_t        raw_reg, raw_next;
    row_t        span_reg, span_next;
    logic [5:0]  x_reg, x_next, y_reg, y_next, top_reg, top_next, len_reg, len_next;
    logic [5:0]  faces_reg, faces_next;
    logic [2:0]  k_reg, k_next;
    logic [5:0]  z_reg, z_next;
    logic [2:0]  rs_status_reg, rs_status_next;
    logic [2:0]  rs_dir_reg, rs_dir_next;
    logic [5:0]  rs_plane_reg, rs_plane_next;
    logic [4:0]  rs_u_reg, rs_u_next;
    logic [4:0]  rs_v_reg, rs_v_next;
    logic [5:0]  rs_w_reg, rs_w_next;
    logic [5:0]  rs_h_reg, rs_h_next;
    logic        m_valid_reg;
    logic [55:0] m_data_reg;
    logic [2:0]  m_user_reg;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    row_t              wdata, rdata;

    logic [6:0]  planes;
    logic [5:0]  wid, hgt;
    logic        fits;
    logic [18:0] tri_total;
    logic [19:0] twice;
    logic [5:0]  ld_plane, ld_row, ld_bit;
    logic [6:0]  ld_end;
    logic [6:0]  row_h;
    row_t        shifted;

    vfgm_ram #(.WIDTH(ROW_W), .DEPTH(ROW_COUNT)) u_rows (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= '0;
            size_y_reg <= '0;
            size_z_reg <= '0;
            exact_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SIZE_X: size_x_reg <= cfg_wdata[5:0];
                REG_SIZE_Y: size_y_reg <= cfg_wdata[5:0];
                REG_SIZE_Z: size_z_reg <= cfg_wdata[5:0];
                REG_EXACT:  exact_reg  <= cfg_wdata;
            endcase
        end
    end

    always_comb begin
        if (face_reg < 3'd2) begin
            planes = {1'b0, size_x_reg} + 7'd1;
            wid    = size_y_reg;
            hgt    = size_z_reg;
        end else if (face_reg < 3'd4) begin
            planes = {1'b0, size_y_reg} + 7'd1;
            wid    = size_x_reg;
            hgt    = size_z_reg;
        end else begin
            planes = {1'b0, size_z_reg} + 7'd1;
            wid    = size_x_reg;
            hgt    = size_y_reg;
        end
    end

    assign fits  = (size_x_reg <= 6'(MAX_DIM)) && (size_y_reg <= 6'(MAX_DIM))
                && (size_z_reg <= 6'(MAX_DIM));
    assign twice = {count_reg, 1'b0};
    assign tri_total = (twice > {1'b0, COUNT_MAX}) ? COUNT_MAX : twice[18:0];
    assign ld_end = {1'b0, top_reg} + {1'b0, len_reg};
    assign row_h  = {1'b0, row_reg} + {1'b0, h_reg};
    assign shifted = bits_reg >> u_reg;

    always_comb begin
        unique case (k_reg)
            3'd0: begin ld_plane = x_reg;          ld_row = z_reg; ld_bit = y_reg; end
            3'd1: begin ld_plane = x_reg + 6'd1;   ld_row = z_reg; ld_bit = y_reg; end
            3'd2: begin ld_plane = y_reg;          ld_row = z_reg; ld_bit = x_reg; end
            3'd3: begin ld_plane = y_reg + 6'd1;   ld_row = z_reg; ld_bit = x_reg; end
            3'd4: begin ld_plane = top_reg;        ld_row = y_reg; ld_bit = x_reg; end
            default: begin
                ld_plane = ld_end[5:0];
                ld_row   = y_reg;
                ld_bit   = x_reg;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        range_err_next = range_err_reg;
        seen_next      = seen_reg;
        count_next     = count_reg;
        face_next      = face_reg;
        plane_next     = plane_reg;
        row_next       = row_reg;
        h_next         = h_reg;
        w_next         = w_reg;
        u_next         = u_reg;
        bits_next      = bits_reg;
        raw_next       = raw_reg;
        span_next      = span_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        top_next       = top_reg;
        len_next       = len_reg;
        faces_next     = faces_reg;
        k_next         = k_reg;
        z_next         = z_reg;
        rs_status_next = rs_status_reg;
        rs_dir_next    = rs_dir_reg;
        rs_plane_next  = rs_plane_reg;
        rs_u_next      = rs_u_reg;
        rs_v_next      = rs_v_reg;
        rs_w_next      = rs_w_reg;
        rs_h_next      = rs_h_reg;
        we    = 1'b0;
        waddr = row_addr(face_reg, plane_reg, row_reg[4:0]);
        wdata = '0;
        raddr = row_addr(face_reg, plane_reg, row_reg[4:0]);
        s_tready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_CLR: begin
                we    = 1'b1;
                waddr = clr_cnt_reg;
                wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(ROW_COUNT - 1)) begin
                    clr_cnt_next = '0;
                    state_next   = clr_reply_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    rs_status_next = ST_ACCEPT;
                    rs_dir_next    = '0;
                    rs_plane_next  = '0;
                    rs_u_next      = '0;
                    rs_v_next      = '0;
                    rs_w_next      = '0;
                    rs_h_next      = '0;
                    x_next     = s_tdata[5:0];
                    y_next     = s_tdata[11:6];
                    top_next   = s_tdata[17:12];
                    len_next   = s_tdata[23:18];
                    faces_next = s_tdata[29:24];
                    k_next     = '0;
                    z_next     = s_tdata[17:12];
                    state_next = S_DONE;
                    unique case (s_tuser)
                        CMD_CLEAR: begin
                            range_err_next = 1'b0;
                            seen_next      = 1'b0;
                            count_next     = '0;
                            face_next      = '0;
                            plane_next     = '0;
                            row_next       = '0;
                            clr_reply_next = 1'b1;
                            state_next     = S_CLR;
                        end
                        CMD_LOAD: begin
                            seen_next = 1'b1;
                            if (!fits || s_tdata[5:0] >= size_x_reg
                                || s_tdata[11:6] >= size_y_reg || s_tdata[23:18] == '0
                                || s_tdata[17:12] >= size_z_reg
                                || ({1'b0, s_tdata[17:12]} + {1'b0, s_tdata[23:18]})
                                   > {1'b0, size_z_reg}) begin
                                range_err_next = 1'b1;
                            end else begin
                                state_next = S_LDSEL;
                            end
                        end
                        CMD_FETCH: begin
                            if (size_x_reg == '0 || size_y_reg == '0 || size_z_reg == '0
                                || !seen_reg || exact_reg == '0) begin
                                rs_status_next = ST_MISSING;
                            end else if (range_err_reg || !fits) begin
                                rs_status_next = ST_RANGE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LDSEL, S_LDWR: begin
                raddr = row_addr(k_reg, ld_plane, ld_row[4:0]);
                waddr = row_addr(k_reg, ld_plane, ld_row[4:0]);
                wdata = rdata | (row_t'(1) << ld_bit[4:0]);
                if (state_reg == S_LDSEL && faces_reg[k_reg]) begin
                    state_next = S_LDWR;
                end else begin
                    we = (state_reg == S_LDWR);
                    state_next = S_LDSEL;
                    if (k_reg < 3'd3) begin
                        k_next = k_reg + 3'd1;
                    end else if (k_reg == 3'd3) begin
                        if ({1'b0, z_reg} + 7'd1 < ld_end) begin
                            z_next = z_reg + 6'd1;
                            k_next = '0;
                        end else begin
                            k_next = 3'd4;
                        end
                    end else if (k_reg == 3'd4) begin
                        k_next = 3'd5;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                priority if (face_reg >= FACE_DONE) begin
                    if (count_reg == '0) begin
                        rs_status_next = ST_EMPTY;
                    end else if ({4'd0, twice} >= exact_reg) begin
                        rs_status_next = ST_NO_SAVE;
                    end else begin
                        rs_status_next = ST_DONE_OK;
                    end
                    state_next = S_DONE;
                end else if ({1'b0, plane_reg} >= planes) begin
                    face_next  = face_reg + 3'd1;
                    plane_next = '0;
                    row_next   = '0;
                end else if (row_reg >= hgt) begin
                    plane_next = plane_reg + 6'd1;
                    row_next   = '0;
                end else begin
                    state_next = S_SDATA;
                end
            end
            S_SDATA: begin
                bits_next = rdata & low_ones(wid);
                raw_next  = rdata;
                if ((rdata & low_ones(wid)) == '0) begin
                    row_next   = row_reg + 6'd1;
                    state_next = S_SCAN;
                end else begin
                    state_next = S_FIND;
                end
            end
            S_FIND: begin
                u_next = '0;
                for (int i = ROW_W - 1; i >= 0; i--) begin
                    if (bits_reg[i]) u_next = 5'(i);
                end
                state_next = S_RUN;
            end
            S_RUN: begin
                w_next = 6'(ROW_W);
                for (int i = ROW_W - 1; i >= 0; i--) begin
                    if (!shifted[i]) w_next = 6'(i);
                end
                state_next = S_SPAN;
            end
            S_SPAN: begin
                span_next = low_ones(w_reg) << u_reg;
                we        = 1'b1;
                wdata     = raw_reg & ~(low_ones(w_reg) << u_reg);
                h_next    = 6'd1;
                state_next = S_HREAD;
            end
            S_HREAD: begin
                raddr = row_addr(face_reg, plane_reg, row_h[4:0]);
                state_next = (row_h < {1'b0, hgt}) ? S_HCHK : S_FIN;
            end
            S_HCHK: begin
                if ((rdata & span_reg) == span_reg) begin
                    we     = 1'b1;
                    waddr  = row_addr(face_reg, plane_reg, row_h[4:0]);
                    wdata  = rdata & ~span_reg;
                    h_next = h_reg + 6'd1;
                    state_next = S_HREAD;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (count_reg != COUNT_MAX) count_next = count_reg + 19'd1;
                rs_status_next = ST_RECT;
                rs_dir_next    = face_reg;
                rs_plane_next  = plane_reg;
                rs_u_next      = u_reg;
                rs_v_next      = row_reg[4:0];
                rs_w_next      = w_reg;
                rs_h_next      = h_reg;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    clr_reply_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            range_err_reg <= 1'b0;
            seen_reg      <= 1'b0;
            count_reg     <= '0;
            face_reg      <= '0;
            plane_reg     <= '0;
            row_reg       <= '0;
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            range_err_reg <= range_err_next;
            seen_reg      <= seen_next;
            count_reg     <= count_next;
            face_reg      <= face_next;
            plane_reg     <= plane_next;
            row_reg       <= row_next;
            k_reg         <= k_next;
            if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        h_reg         <= h_next;
        w_reg         <= w_next;
        u_reg         <= u_next;
        bits_reg      <= bits_next;
        raw_reg       <= raw_next;
        span_reg      <= span_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        top_reg       <= top_next;
        len_reg       <= len_next;
        faces_reg     <= faces_next;
        z_reg         <= z_next;
        rs_status_reg <= rs_status_next;
        rs_dir_reg    <= rs_dir_next;
        rs_plane_reg  <= rs_plane_next;
        rs_u_reg      <= rs_u_next;
        rs_v_reg      <= rs_v_next;
        rs_w_reg      <= rs_w_next;
        rs_h_reg      <= rs_h_next;
        if (state_reg == S_DONE && (!m_valid_reg || m_tready)) begin
            m_user_reg <= rs_status_reg;
            m_data_reg <= {6'd0, tri_total, rs_h_reg, rs_w_reg, rs_v_reg, rs_u_reg,
                           rs_plane_reg, rs_dir_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_clr_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLR |-> !s_tready)
        else $error("input taken during clearing pass");
    a_rect_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_RECT |-> m_tdata[24:19] != '0 && m_tdata[30:25] != '0)
        else $error("empty rectangle reported");
    a_nonrect_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_RECT |-> m_tdata[30:0] == '0)
        else $error("rectangle fields set on status result");
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |=> count_reg >= $past(count_reg) || state_reg == S_CLR)
        else $error("rectangle count decreased");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import vfgm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  face_dir;
        logic [5:0]  plane_index;
        logic [4:0]  rect_u;
        logic [4:0]  rect_v;
        logic [5:0]  rect_width;
        logic [5:0]  rect_height;
        logic [18:0] triangle_total;
    } mesh_res_t;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  cmd;
        logic [5:0]  x, y, top, len, faces;
        logic [23:0] val;
        bit          typed;
        logic [2:0]  st;
    } step_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = CMD_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = REG_SIZE_X;
    logic [23:0] cfg_wdata = '0;

    voxel_face_greedy_mesher_top u_top (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // mesher shadow state
    logic [31:0] face_rows [6][MAX_DIM+1][MAX_DIM];
    int          scan_face, scan_plane, scan_row;
    bit          range_err, slab_seen;
    int          rect_n;
    int          sz_x, sz_y, sz_z;
    int          exact_tris;

    mesh_res_t   pending_res[$];
    int          n_accepted;
    int          n_errors;
    logic [2:0]  last_status;
    int          gap_pct, stall_pct;
    bit          typed_on;
    logic [2:0]  typed_st;

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic void stash_result(input mesh_res_t r);
        pending_res.insert(pending_res.size(), r);
    endfunction

    function automatic logic [31:0] ones(input int w);
        logic [63:0] m;
        m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        return m[31:0];
    endfunction

    function automatic void clear_masks();
        foreach (face_rows[f, p, r]) face_rows[f][p][r] = '0;
        scan_face = 0; scan_plane = 0; scan_row = 0;
        range_err = 0; slab_seen = 0; rect_n = 0;
    endfunction

    function automatic bit sizes_fit();
        return sz_x <= MAX_DIM && sz_y <= MAX_DIM && sz_z <= MAX_DIM;
    endfunction

    function automatic void add_slab(input logic [31:0] d);
        int x, y, top, len, fb;
        x = int'(d[5:0]); y = int'(d[11:6]); top = int'(d[17:12]);
        len = int'(d[23:18]); fb = int'(d[29:24]);
        slab_seen = 1;
        if (!sizes_fit() || x >= sz_x || y >= sz_y || len == 0 || top >= sz_z ||
            top + len > sz_z) begin
            range_err = 1;
            return;
        end
        for (int z = top; z < top + len; z++) begin
            if (fb[0]) face_rows[0][x][z][y] = 1'b1;
            if (fb[1]) face_rows[1][x+1][z][y] = 1'b1;
            if (fb[2]) face_rows[2][y][z][x] = 1'b1;
            if (fb[3]) face_rows[3][y+1][z][x] = 1'b1;
        end
        if (fb[4]) face_rows[4][top][y][x] = 1'b1;
        if (fb[5]) face_rows[5][top+len][y][x] = 1'b1;
    endfunction

    function automatic bit take_rect(inout mesh_res_t r);
        int planes, wid, hgt, u, w, h;
        logic [31:0] bits, span;
        while (scan_face < FACE_DONE) begin
            if (scan_face < 2) begin
                planes = sz_x + 1; wid = sz_y; hgt = sz_z;
            end else if (scan_face < 4) begin
                planes = sz_y + 1; wid = sz_x; hgt = sz_z;
            end else begin
                planes = sz_z + 1; wid = sz_x; hgt = sz_y;
            end
            if (scan_plane >= planes) begin
                scan_face++; scan_plane = 0; scan_row = 0;
                continue;
            end
            if (scan_row >= hgt) begin
                scan_plane++; scan_row = 0;
                continue;
            end
            bits = face_rows[scan_face][scan_plane][scan_row] & ones(wid);
            if (bits == '0) begin
                scan_row++;
                continue;
            end
            u = 0;
            while (!bits[u]) u++;
            w = 1;
            while (u + w < wid && bits[u+w]) w++;
            span = ones(w) << u;
            h = 1;
            while (scan_row + h < hgt &&
                   (face_rows[scan_face][scan_plane][scan_row+h] & span) == span) h++;
            for (int k = 0; k < h; k++)
                face_rows[scan_face][scan_plane][scan_row+k] &= ~span;
            if (rect_n < COUNT_MAX) rect_n++;
            r.status = ST_RECT;
            r.face_dir = 3'(scan_face);
            r.plane_index = 6'(scan_plane);
            r.rect_u = 5'(u);
            r.rect_v = 5'(scan_row);
            r.rect_width = 6'(w);
            r.rect_height = 6'(h);
            return 1;
        end
        return 0;
    endfunction

    function automatic mesh_res_t mesh_step(input logic [1:0] c, input logic [31:0] d);
        mesh_res_t r;
        longint t;
        r = '0;
        r.status = ST_ACCEPT;
        case (c)
            CMD_CLEAR: clear_masks();
            CMD_LOAD:  add_slab(d);
            CMD_FETCH: begin
                if (sz_x == 0 || sz_y == 0 || sz_z == 0 || !slab_seen || exact_tris == 0)
                    r.status = ST_MISSING;
                else if (range_err || !sizes_fit())
                    r.status = ST_RANGE;
                else if (!take_rect(r)) begin
                    if (rect_n == 0) r.status = ST_EMPTY;
                    else if (longint'(rect_n) * 2 >= exact_tris) r.status = ST_NO_SAVE;
                    else r.status = ST_DONE_OK;
                end
            end
            default: ;
        endcase
        t = longint'(rect_n) * 2;
        r.triangle_total = (t > COUNT_MAX) ? COUNT_MAX : 19'(t);
        return r;
    endfunction

    always @(posedge aclk) begin
        mesh_res_t r;
        if (aresetn && s_tvalid && s_tready) begin
            r = mesh_step(s_tuser, s_tdata);
            if (typed_on) r = '{status: typed_st, triangle_total: r.triangle_total,
                                default: '0};
            stash_result(r);
            last_status = r.status;
            n_accepted++;
        end
    end

    always @(posedge aclk) begin
        mesh_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_res.size() == 0) begin
                flag_mismatch("unexpected result count", 1, 0);
            end else begin
                want = pending_res.pop_front();
                if (m_tuser != want.status) flag_mismatch("status", m_tuser, want.status);
                if (m_tdata[2:0] != want.face_dir)
                    flag_mismatch("face_dir", m_tdata[2:0], want.face_dir);
                if (m_tdata[8:3] != want.plane_index)
                    flag_mismatch("plane_index", m_tdata[8:3], want.plane_index);
                if (m_tdata[13:9] != want.rect_u)
                    flag_mismatch("rect_u", m_tdata[13:9], want.rect_u);
                if (m_tdata[18:14] != want.rect_v)
                    flag_mismatch("rect_v", m_tdata[18:14], want.rect_v);
                if (m_tdata[24:19] != want.rect_width)
                    flag_mismatch("rect_width", m_tdata[24:19], want.rect_width);
                if (m_tdata[30:25] != want.rect_height)
                    flag_mismatch("rect_height", m_tdata[30:25], want.rect_height);
                if (m_tdata[49:31] != want.triangle_total)
                    flag_mismatch("triangle_total", m_tdata[49:31], want.triangle_total);
            end
        end
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_cmd(input logic [1:0] c, input logic [31:0] d);
        int target;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        target = n_accepted + 1;
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= d;
        do @(negedge aclk); while (n_accepted != target);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_res.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] a, input logic [23:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (a)
            REG_SIZE_X: sz_x = int'(v[5:0]);
            REG_SIZE_Y: sz_y = int'(v[5:0]);
            REG_SIZE_Z: sz_z = int'(v[5:0]);
            default:    exact_tris = int'(v);
        endcase
        @(negedge aclk);
    endtask

    task automatic set_grid(input int x, input int y, input int z, input int ex);
        write_reg(REG_SIZE_X, 24'(x));
        write_reg(REG_SIZE_Y, 24'(y));
        write_reg(REG_SIZE_Z, 24'(z));
        write_reg(REG_EXACT, 24'(ex));
    endtask

    function automatic logic [31:0] pack_slab(input int x, input int y, input int top,
                                               input int len, input int fb);
        logic [31:0] d;
        d = '0;
        d[5:0] = 6'(x); d[11:6] = 6'(y); d[17:12] = 6'(top);
        d[23:18] = 6'(len); d[29:24] = 6'(fb);
        return d;
    endfunction

    function automatic step_t it(input logic [1:0] c, input int x, input int y,
                                 input int top, input int len, input int fb,
                                 input bit ty, input logic [2:0] st);
        step_t s;
        s = '{is_cfg: 0, cmd: c, x: 6'(x), y: 6'(y), top: 6'(top), len: 6'(len),
              faces: 6'(fb), val: 0, typed: ty, st: st};
        return s;
    endfunction

    function automatic step_t cf(input logic [1:0] a, input int v);
        step_t s;
        s = '{is_cfg: 1, cmd: a, val: 24'(v), default: 0};
        return s;
    endfunction

    function automatic logic [31:0] good_slab();
        int top;
        top = $urandom_range(sz_z - 1);
        return pack_slab($urandom_range(sz_x - 1), $urandom_range(sz_y - 1), top,
                         $urandom_range(sz_z - top, 1), $urandom_range(63));
    endfunction

    task automatic mesh_run(input int n_loads);
        int fetches;
        send_cmd(CMD_CLEAR, $urandom);
        for (int i = 0; i < n_loads; i++) begin
            if ($urandom_range(99) < 8) send_cmd(CMD_LOAD, $urandom);
            else send_cmd(CMD_LOAD, good_slab());
            if ($urandom_range(99) < 4) send_cmd(CMD_UNUSED, $urandom);
            if ($urandom_range(99) < 10) send_cmd(CMD_FETCH, $urandom);
        end
        fetches = 0;
        do begin
            send_cmd(CMD_FETCH, $urandom);
            fetches++;
            if (last_status == ST_RECT && $urandom_range(99) < 5)
                send_cmd(CMD_LOAD, good_slab());
        end while (last_status == ST_RECT && fetches < 400);
        repeat ($urandom_range(2)) send_cmd(CMD_FETCH, $urandom);
    endtask

    step_t directed[] = '{
        it(CMD_FETCH, 0, 0, 0, 0, 0, 1, ST_MISSING),
        it(CMD_UNUSED, 63, 63, 63, 63, 63, 1, ST_ACCEPT),
        cf(REG_SIZE_X, 4), cf(REG_SIZE_Y, 3), cf(REG_SIZE_Z, 5), cf(REG_EXACT, 3),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 1, ST_MISSING),
        it(CMD_LOAD, 0, 0, 0, 5, 63, 1, ST_ACCEPT),
        it(CMD_LOAD, 3, 2, 4, 1, 63, 1, ST_ACCEPT),
        it(CMD_LOAD, 3, 2, 0, 0, 63, 1, ST_ACCEPT),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 1, ST_RANGE),
        it(CMD_CLEAR, 0, 0, 0, 0, 0, 1, ST_ACCEPT),
        it(CMD_LOAD, 0, 0, 0, 5, 63, 0, 0),
        it(CMD_LOAD, 3, 2, 4, 1, 63, 0, 0),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 0, 0),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 0, 0),
        it(CMD_CLEAR, 0, 0, 0, 0, 0, 1, ST_ACCEPT),
        it(CMD_LOAD, 1, 1, 2, 3, 0, 1, ST_ACCEPT),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 1, ST_EMPTY),
        it(CMD_CLEAR, 0, 0, 0, 0, 0, 1, ST_ACCEPT),
        it(CMD_LOAD, 63, 63, 63, 63, 63, 1, ST_ACCEPT),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 1, ST_RANGE),
        cf(REG_SIZE_X, 40),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 1, ST_RANGE),
        it(CMD_CLEAR, 0, 0, 0, 0, 0, 1, ST_ACCEPT),
        it(CMD_FETCH, 0, 0, 0, 0, 0, 1, ST_MISSING)
    };

    initial begin
        #100_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int mode;
        clear_masks();
        sz_x = 0; sz_y = 0; sz_z = 0; exact_tris = 0;
        n_accepted = 0; n_errors = 0;
        gap_pct = 0; stall_pct = 0;
        typed_on = 0; typed_st = ST_ACCEPT;
        last_status = ST_ACCEPT;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                write_reg(directed[i].cmd, directed[i].val);
            end else begin
                typed_on = directed[i].typed;
                typed_st = directed[i].st;
                send_cmd(directed[i].cmd, pack_slab(directed[i].x, directed[i].y,
                         directed[i].top, directed[i].len, directed[i].faces));
            end
        end
        typed_on = 0;

        mode = 0;
        while (n_accepted < 1450) begin
            wait_idle();
            case (mode % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 63; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 63; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase
            case (mode % 7)
                0: set_grid(1, 1, 1, 1);
                1: set_grid(32, 32, 32, 24'hFFFFFF);
                2: set_grid($urandom_range(6, 1), $urandom_range(6, 1),
                            $urandom_range(6, 1), $urandom_range(24, 1));
                3: set_grid($urandom_range(8, 1), $urandom_range(8, 1),
                            $urandom_range(8, 1), $urandom_range(24'hFFFFFF, 200));
                default: set_grid($urandom_range(5, 2), $urandom_range(5, 2),
                                  $urandom_range(5, 2), $urandom_range(60, 1));
            endcase
            repeat ((mode % 7 == 1) ? 1 : 4)
                mesh_run($urandom_range((mode % 7 == 1) ? 30 : 12, 1));
            mode++;
        end

        s_tvalid <= 1'b0;
        gap_pct = 0;
        @(negedge aclk);
        while (pending_res.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
